// File: src/register_file_integer_alu_defines.svh
// Assertion macros shared by the checker of the register file ALU.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef REGISTER_FILE_INTEGER_ALU_DEFINES_SVH
`define REGISTER_FILE_INTEGER_ALU_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define RFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/rfa_pkg.sv
// Package of the register file ALU: opcodes, state types, control struct.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rfa_pkg;

  // Fixed field widths of the item ports
  localparam int unsigned FIELD_OP_W  = 3;
  localparam int unsigned FIELD_IDX_W = 5;
  localparam int unsigned FIELD_VAL_W = 32;

  typedef enum logic [FIELD_OP_W-1:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_MOD  = 3'd4,
    OP_LOAD = 3'd5
  } op_e;

  // Sequencer of the top level
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_SRC,
    ST_READ_DST,
    ST_DISPATCH,
    ST_WAIT,
    ST_DONE
  } state_e;

  // Iterative arithmetic unit
  typedef enum logic [2:0] {
    A_IDLE,
    A_PREP,
    A_ITER,
    A_FIX,
    A_ADJ,
    A_DONE
  } alu_state_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } alu_ctrl_t;

endpackage

`default_nettype wire

// File: src/rfa_regfile.sv
// Register file of the ALU: memory with two registered read ports, one write.
// Per-entry valid bits give the all-zero reset. Depends on rfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfa_regfile #(
  parameter int unsigned REGISTER_COUNT = 32,
  parameter int unsigned DATA_WIDTH     = 32,
  parameter int unsigned IDX_W          = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IDX_W-1:0]      rd_addr_a_i,
  input  logic [IDX_W-1:0]      rd_addr_b_i,
  output logic [DATA_WIDTH-1:0] rd_data_a_o,
  output logic [DATA_WIDTH-1:0] rd_data_b_o,
  input  logic                  wr_en_i,
  input  logic [IDX_W-1:0]      wr_addr_i,
  input  logic [DATA_WIDTH-1:0] wr_data_i
);
  import rfa_pkg::*;

  logic [DATA_WIDTH-1:0] mem_q [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] valid_q;
  logic [DATA_WIDTH-1:0] rd_data_a_q;
  logic [DATA_WIDTH-1:0] rd_data_b_q;

  // Entries never written since reset read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  // Storage and registered reads
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_a_q <= valid_q[rd_addr_a_i] ? mem_q[rd_addr_a_i] : '0;
    rd_data_b_q <= valid_q[rd_addr_b_i] ? mem_q[rd_addr_b_i] : '0;
  end

  assign rd_data_a_o = rd_data_a_q;
  assign rd_data_b_o = rd_data_b_q;

endmodule

`default_nettype wire

// File: src/rfa_serial_alu.sv
// Iterative arithmetic unit: bit-serial add/sub, shift-add multiply and
// restoring divide, one operand bit per cycle. Depends on rfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfa_serial_alu #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rfa_pkg::alu_ctrl_t    ctrl_i,
  input  logic [DATA_WIDTH-1:0] a_i,
  input  logic [DATA_WIDTH-1:0] b_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] result_o
);
  import rfa_pkg::*;

  localparam int unsigned CntW = $clog2(DATA_WIDTH);
  localparam logic [CntW-1:0] LastCnt = CntW'(DATA_WIDTH - 1);

  alu_state_e state_q, state_d;
  op_e op_q, op_d;
  logic [DATA_WIDTH-1:0] x_q, x_d;     // left operand / dividend / quotient
  logic [DATA_WIDTH-1:0] y_q, y_d;     // right operand / divisor magnitude
  logic [DATA_WIDTH-1:0] acc_q, acc_d; // result / partial remainder
  logic [DATA_WIDTH-1:0] div_q, div_d; // divisor as given, for the mod fixup
  logic carry_q, carry_d;
  logic nega_q, nega_d;
  logic negq_q, negq_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [DATA_WIDTH-1:0] rem_sh;
  logic [DATA_WIDTH:0]   trial;
  logic                  sum_bit;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      A_IDLE: begin
        if (ctrl_i.start) begin
          state_d = (ctrl_i.op == OP_DIV || ctrl_i.op == OP_MOD) ? A_PREP : A_ITER;
        end
      end
      A_PREP: state_d = A_ITER;
      A_ITER: begin
        if (cnt_q == '0) begin
          state_d = (op_q == OP_DIV || op_q == OP_MOD) ? A_FIX : A_DONE;
        end
      end
      A_FIX:  state_d = (op_q == OP_MOD) ? A_ADJ : A_DONE;
      A_ADJ:  state_d = A_DONE;
      A_DONE: state_d = A_IDLE;
      default: state_d = A_IDLE;
    endcase
  end

  // Datapath
  always_comb begin
    op_d    = op_q;
    x_d     = x_q;
    y_d     = y_q;
    acc_d   = acc_q;
    div_d   = div_q;
    carry_d = carry_q;
    nega_d  = nega_q;
    negq_d  = negq_q;
    cnt_d   = cnt_q;

    sum_bit = x_q[0] ^ y_q[0] ^ carry_q;
    rem_sh  = {acc_q[DATA_WIDTH-2:0], x_q[DATA_WIDTH-1]};
    trial   = {1'b0, rem_sh} - {1'b0, y_q};

    unique case (state_q)
      A_IDLE: begin
        if (ctrl_i.start) begin
          op_d    = ctrl_i.op;
          x_d     = a_i;
          y_d     = (ctrl_i.op == OP_SUB) ? ~b_i : b_i;
          acc_d   = '0;
          div_d   = b_i;
          carry_d = (ctrl_i.op == OP_SUB);
          nega_d  = a_i[DATA_WIDTH-1];
          negq_d  = a_i[DATA_WIDTH-1] ^ b_i[DATA_WIDTH-1];
          cnt_d   = LastCnt;
        end
      end
      // Magnitudes for the unsigned divide
      A_PREP: begin
        x_d = nega_q ? (~x_q + 1'b1) : x_q;
        y_d = y_q[DATA_WIDTH-1] ? (~y_q + 1'b1) : y_q;
      end
      A_ITER: begin
        cnt_d = cnt_q - 1'b1;
        case (op_q) inside
          OP_ADD, OP_SUB: begin
            acc_d   = {sum_bit, acc_q[DATA_WIDTH-1:1]};
            carry_d = (x_q[0] & y_q[0]) | (carry_q & (x_q[0] ^ y_q[0]));
            x_d     = {1'b0, x_q[DATA_WIDTH-1:1]};
            y_d     = {1'b0, y_q[DATA_WIDTH-1:1]};
          end
          OP_MUL: begin
            if (y_q[0]) begin
              acc_d = acc_q + x_q;
            end
            x_d = {x_q[DATA_WIDTH-2:0], 1'b0};
            y_d = {1'b0, y_q[DATA_WIDTH-1:1]};
          end
          OP_DIV, OP_MOD: begin
            acc_d = trial[DATA_WIDTH] ? rem_sh : trial[DATA_WIDTH-1:0];
            x_d   = {x_q[DATA_WIDTH-2:0], ~trial[DATA_WIDTH]};
          end
          default: ;
        endcase
      end
      // Signs of quotient or remainder
      A_FIX: begin
        if (op_q == OP_DIV) begin
          acc_d = negq_q ? (~x_q + 1'b1) : x_q;
        end else begin
          acc_d = nega_q ? (~acc_q + 1'b1) : acc_q;
        end
      end
      // Negative remainder gets the divisor added
      A_ADJ: begin
        if (acc_q[DATA_WIDTH-1]) begin
          acc_d = acc_q + div_q;
        end
      end
      A_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    x_q     <= x_d;
    y_q     <= y_d;
    acc_q   <= acc_d;
    div_q   <= div_d;
    carry_q <= carry_d;
    nega_q  <= nega_d;
    negq_q  <= negq_d;
    cnt_q   <= cnt_d;
  end

  assign done_o   = (state_q == A_DONE);
  assign result_o = acc_q;

endmodule

`default_nettype wire

// File: src/register_file_integer_alu.sv
// Top level of the register file ALU: sequencer, index reduction, output register.
// Depends on rfa_pkg, rfa_regfile and rfa_serial_alu.
//
// Use: one input channel (in_valid_i / in_ready_o) carries an instruction item
// (op, destination, two sources, immediate); one output channel (out_valid_o /
// out_ready_i) returns the destination's new value, its index and the
// divide-by-zero flag. Items are handled one at a time; in_ready_o is high
// while the sequencer is idle, also while an earlier result waits in the
// output register.
// LOAD, undefined ops and zero divisors bypass the serial unit. ADD, SUB and
// MUL go through it; DIV and MOD add a magnitude step before it and a sign fix
// after, and MOD a remainder adjust at the end. The serial unit takes one operand
// bit per cycle. Registered reads of the file fetch both sources, then the
// destination, before dispatch.
// Reset clears every register of the file to zero at once (valid bits) and
// empties the output register. When the receiver stalls, the finished item
// waits in the sequencer and the file is written only as the result moves to
// the output register.
`timescale 1ns / 1ps
`default_nettype none

module register_file_integer_alu #(
  parameter int unsigned REGISTER_COUNT = 32,
  parameter int unsigned DATA_WIDTH     = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [rfa_pkg::FIELD_OP_W-1:0]         op_i,
  input  logic [rfa_pkg::FIELD_IDX_W-1:0]        dest_index_i,
  input  logic [rfa_pkg::FIELD_IDX_W-1:0]        first_source_i,
  input  logic [rfa_pkg::FIELD_IDX_W-1:0]        second_source_i,
  input  logic signed [rfa_pkg::FIELD_VAL_W-1:0] immediate_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [rfa_pkg::FIELD_VAL_W-1:0] written_value_o,
  output logic [rfa_pkg::FIELD_IDX_W-1:0]        written_index_o,
  output logic                                   divide_by_zero_o
);
  import rfa_pkg::*;

  localparam int unsigned IdxW = $clog2(REGISTER_COUNT);
  localparam logic [8:0] RegCount9 = 9'(REGISTER_COUNT);

  // Index modulo the register count, one bit per step
  function automatic logic [IdxW-1:0] reduce_index(input logic [FIELD_IDX_W-1:0] idx);
    logic [8:0] rem;
    rem = '0;
    for (int i = FIELD_IDX_W - 1; i >= 0; i--) begin
      rem = {rem[7:0], idx[i]};
      if (rem >= RegCount9) begin
        rem = rem - RegCount9;
      end
    end
    return IdxW'(rem);
  endfunction

  state_e state_q, state_d;
  op_e op_q;
  logic [IdxW-1:0] dst_q, src1_q, src2_q;
  logic [DATA_WIDTH-1:0] imm_q, a_q, b_q, res_q;
  logic wr_q, flag_q;

  logic out_valid_q;
  logic signed [FIELD_VAL_W-1:0] out_value_q;
  logic [FIELD_IDX_W-1:0] out_index_q;
  logic out_flag_q;

  logic in_accept, out_free, b_nz, use_alu, alu_done;
  logic [IdxW-1:0] rd_addr_a;
  logic [DATA_WIDTH-1:0] rd_data_a, rd_data_b, alu_result;
  logic rf_wr_en;
  alu_ctrl_t alu_ctrl;

  assign in_accept = in_valid_i & in_ready_o;
  assign out_free  = ~out_valid_q | out_ready_i;
  assign b_nz      = |b_q;

  // Which ops go through the serial unit
  always_comb begin
    unique case (op_q) inside
      OP_ADD, OP_SUB, OP_MUL: use_alu = 1'b1;
      OP_DIV, OP_MOD:         use_alu = b_nz;
      default:                use_alu = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_accept) state_d = ST_READ_SRC;
      ST_READ_SRC: state_d = ST_READ_DST;
      ST_READ_DST: state_d = ST_DISPATCH;
      ST_DISPATCH: state_d = use_alu ? ST_WAIT : ST_DONE;
      ST_WAIT:     if (alu_done) state_d = ST_DONE;
      ST_DONE:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o     = (state_q == ST_IDLE);
    rd_addr_a      = (state_q == ST_READ_DST) ? dst_q : src1_q;
    alu_ctrl.start = (state_q == ST_DISPATCH) && use_alu;
    alu_ctrl.op    = op_q;
    rf_wr_en       = (state_q == ST_DONE) && out_free && wr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Item fields, operands and result
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= op_e'(op_i);
      dst_q  <= reduce_index(dest_index_i);
      src1_q <= reduce_index(first_source_i);
      src2_q <= reduce_index(second_source_i);
      imm_q  <= DATA_WIDTH'(immediate_i);
    end
    if (state_q == ST_READ_DST) begin
      a_q <= rd_data_a;
      b_q <= rd_data_b;
    end
    if (state_q == ST_DISPATCH) begin
      unique case (op_q) inside
        OP_DIV, OP_MOD: begin
          res_q  <= rd_data_a;
          wr_q   <= 1'b0;
          flag_q <= ~b_nz;
        end
        OP_LOAD: begin
          res_q  <= imm_q;
          wr_q   <= 1'b1;
          flag_q <= 1'b0;
        end
        default: begin
          res_q  <= rd_data_a;
          wr_q   <= 1'b0;
          flag_q <= 1'b0;
        end
      endcase
    end
    if (state_q == ST_WAIT && alu_done) begin
      res_q <= alu_result;
      wr_q  <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_value_q <= FIELD_VAL_W'($signed(res_q));
      out_index_q <= FIELD_IDX_W'(dst_q);
      out_flag_q  <= flag_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign written_value_o  = out_value_q;
  assign written_index_o  = out_index_q;
  assign divide_by_zero_o = out_flag_q;

  rfa_regfile #(
    .REGISTER_COUNT(REGISTER_COUNT),
    .DATA_WIDTH    (DATA_WIDTH),
    .IDX_W         (IdxW)
  ) u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_a_i(rd_addr_a),
    .rd_addr_b_i(src2_q),
    .rd_data_a_o(rd_data_a),
    .rd_data_b_o(rd_data_b),
    .wr_en_i    (rf_wr_en),
    .wr_addr_i  (dst_q),
    .wr_data_i  (res_q)
  );

  rfa_serial_alu #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (alu_ctrl),
    .a_i     (a_q),
    .b_i     (b_q),
    .done_o  (alu_done),
    .result_o(alu_result)
  );

endmodule

`default_nettype wire

// File: src/rfa_checker.sv
// Port-level checker of the register file ALU and its bind to the top level.
// Depends on register_file_integer_alu_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "register_file_integer_alu_defines.svh"

module rfa_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] written_value_o,
  input wire logic [4:0]  written_index_o,
  input wire logic        divide_by_zero_o
);

  // One item at a time: ready drops right after an item is taken
  `RFA_ASSERT_NXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "ready stayed high after an accepted item")

  // No result shows up too soon after an accepted item
  `RFA_ASSERT_IMP(a_min_latency, clk_i, rst_ni, $rose(out_valid_o), !$past(in_valid_i && in_ready_o, 1) && !$past(in_valid_i && in_ready_o, 2), "result appeared too soon after an item")

  // A stalled result holds
  `RFA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(written_value_o) && $stable(written_index_o) && $stable(divide_by_zero_o), "stalled result changed")

endmodule

bind register_file_integer_alu rfa_checker u_rfa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .written_value_o (written_value_o),
  .written_index_o (written_index_o),
  .divide_by_zero_o(divide_by_zero_o)
);

`default_nettype wire

// File: tb/register_file_integer_alu_tb.sv
// Self-checking testbench of register_file_integer_alu: directed and random
// instruction items, a behavioral register-file predictor and an in-order scoreboard.
// Depends on rfa_pkg and the RTL of register_file_integer_alu.
`timescale 1ns / 1ps

module register_file_integer_alu_tb;
  import rfa_pkg::*;

  // Opcodes the block leaves undefined; they write nothing
  localparam logic [FIELD_OP_W-1:0] OP_UNDEF_LO = 3'd6;
  localparam logic [FIELD_OP_W-1:0] OP_UNDEF_HI = 3'd7;

  localparam logic signed [FIELD_VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [FIELD_VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  localparam int unsigned RANDOM_ITEMS = 740;
  localparam int unsigned TAIL_ITEMS   = 40;

  typedef struct {
    logic signed [FIELD_VAL_W-1:0] value;
    logic [FIELD_IDX_W-1:0]        index;
    logic                          div_zero;
  } writeback_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                          in_valid_i      = 1'b0;
  logic                          in_ready_o;
  logic [FIELD_OP_W-1:0]         op_i            = '0;
  logic [FIELD_IDX_W-1:0]        dest_index_i    = '0;
  logic [FIELD_IDX_W-1:0]        first_source_i  = '0;
  logic [FIELD_IDX_W-1:0]        second_source_i = '0;
  logic signed [FIELD_VAL_W-1:0] immediate_i     = '0;
  logic                          out_valid_o;
  logic                          out_ready_i     = 1'b0;
  logic signed [FIELD_VAL_W-1:0] written_value_o;
  logic [FIELD_IDX_W-1:0]        written_index_o;
  logic                          divide_by_zero_o;

  // Predicted register file and the writebacks still to come back
  logic signed [FIELD_VAL_W-1:0] shadow_regs [32];
  writeback_t                    pending_writebacks [$];
  int unsigned                   fail_count = 0;
  bit                            steady_tail = 1'b0;

  register_file_integer_alu i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .dest_index_i     (dest_index_i),
    .first_source_i   (first_source_i),
    .second_source_i  (second_source_i),
    .immediate_i      (immediate_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .written_value_o  (written_value_o),
    .written_index_o  (written_index_o),
    .divide_by_zero_o (divide_by_zero_o)
  );

  // Clock and reset
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Runs one instruction on the shadow file and returns its writeback
  function automatic writeback_t execute_instr(logic [FIELD_OP_W-1:0] op,
                                               logic [FIELD_IDX_W-1:0] dst,
                                               logic [FIELD_IDX_W-1:0] src_a,
                                               logic [FIELD_IDX_W-1:0] src_b,
                                               logic signed [FIELD_VAL_W-1:0] imm);
    writeback_t wb;
    longint     lhs;
    longint     rhs;
    longint     rem;
    lhs = shadow_regs[src_a];
    rhs = shadow_regs[src_b];
    wb.div_zero = 1'b0;
    case (op)
      OP_ADD:  shadow_regs[dst] = FIELD_VAL_W'(lhs + rhs);
      OP_SUB:  shadow_regs[dst] = FIELD_VAL_W'(lhs - rhs);
      OP_MUL:  shadow_regs[dst] = FIELD_VAL_W'(lhs * rhs);
      OP_DIV: begin
        // 64-bit quotient; min / -1 wraps back to min on truncation
        if (rhs == 0) wb.div_zero = 1'b1;
        else shadow_regs[dst] = FIELD_VAL_W'(lhs / rhs);
      end
      OP_MOD: begin
        // truncated remainder, divisor added when negative (any divisor sign)
        if (rhs == 0) begin
          wb.div_zero = 1'b1;
        end else begin
          rem = lhs % rhs;
          if (rem < 0) rem = rem + rhs;
          shadow_regs[dst] = FIELD_VAL_W'(rem);
        end
      end
      OP_LOAD: shadow_regs[dst] = imm;
      default: ;
    endcase
    wb.value = shadow_regs[dst];
    wb.index = dst;
    return wb;
  endfunction

  // Scoreboard: check the returned item first, then predict the accepted one
  always @(posedge clk_i) begin : scoreboard
    writeback_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_writebacks.size() == 0) begin
          $error("result item with nothing expected: index %0d value %0d",
                 written_index_o, written_value_o);
          fail_count++;
        end else begin
          want = pending_writebacks.pop_front();
          if (written_value_o !== want.value) begin
            $error("written_value: expected %0d, got %0d", want.value, written_value_o);
            fail_count++;
          end
          if (written_index_o !== want.index) begin
            $error("written_index: expected %0d, got %0d", want.index, written_index_o);
            fail_count++;
          end
          if (divide_by_zero_o !== want.div_zero) begin
            $error("divide_by_zero: expected %0d, got %0d", want.div_zero,
                   divide_by_zero_o);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        pending_writebacks.push_back(execute_instr(op_i, dest_index_i, first_source_i,
                                                   second_source_i, immediate_i));
      end
    end
  end

  // Receiver: ready bursts with random stall bursts, always ready in the tail
  initial begin
    forever begin
      if (!steady_tail && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // Drives one item and holds it until accepted, then maybe idles a burst
  task automatic send_instr(logic [FIELD_OP_W-1:0] op, logic [FIELD_IDX_W-1:0] dst,
                            logic [FIELD_IDX_W-1:0] src_a, logic [FIELD_IDX_W-1:0] src_b,
                            logic signed [FIELD_VAL_W-1:0] imm = '0);
    in_valid_i      <= 1'b1;
    op_i            <= op;
    dest_index_i    <= dst;
    first_source_i  <= src_a;
    second_source_i <= src_b;
    immediate_i     <= imm;
    do @(posedge clk_i); while (!in_ready_o);
    if (!steady_tail && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // Holds the sender off until every outstanding writeback is back;
  // it first lets the scoreboard log the last accepted item
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_writebacks.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [FIELD_VAL_W-1:0] pick_immediate();
    logic signed [FIELD_VAL_W-1:0] edges [5] = '{VAL_MIN, VAL_MAX, -32'sd1, 32'sd0, 32'sd1};
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $signed($urandom_range(0, 40)) - 32'sd20;
      2:       return edges[$urandom_range(0, 4)];
      default: return $signed($urandom_range(0, 2000)) - 32'sd1000;
    endcase
  endfunction

  function automatic logic [FIELD_OP_W-1:0] pick_op();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return OP_LOAD;
    if (roll < 40) return OP_ADD;
    if (roll < 50) return OP_SUB;
    if (roll < 60) return OP_MUL;
    if (roll < 76) return OP_DIV;
    if (roll < 92) return OP_MOD;
    if (roll < 96) return OP_UNDEF_LO;
    return OP_UNDEF_HI;
  endfunction

  // Extreme values into the file, highest index included
  task automatic test_load_extremes();
    send_instr(OP_LOAD, 5'd1, 5'd0, 5'd0, VAL_MAX);
    send_instr(OP_LOAD, 5'd2, 5'd0, 5'd0, VAL_MIN);
    send_instr(OP_LOAD, 5'd3, 5'd0, 5'd0, -32'sd1);
    send_instr(OP_LOAD, 5'd4, 5'd0, 5'd0, 32'sd1);
    send_instr(OP_LOAD, 5'd5, 5'd0, 5'd0, 32'sd0);
    send_instr(OP_LOAD, 5'd6, 5'd0, 5'd0, -32'sd7);
    send_instr(OP_LOAD, 5'd7, 5'd0, 5'd0, -32'sd2);
    send_instr(OP_LOAD, 5'd8, 5'd0, 5'd0, 32'sd7);
    send_instr(OP_LOAD, 5'd31, 5'd0, 5'd0, 32'sh5a5a_a5a5);
  endtask

  // Wrap-around of add, sub and mul
  task automatic test_wrapping_arith();
    send_instr(OP_ADD, 5'd9, 5'd1, 5'd4);
    send_instr(OP_SUB, 5'd10, 5'd2, 5'd4);
    send_instr(OP_MUL, 5'd11, 5'd1, 5'd1);
    send_instr(OP_MUL, 5'd12, 5'd2, 5'd3);
    send_instr(OP_ADD, 5'd0, 5'd31, 5'd31);
  endtask

  // Truncating division, min by minus one, zero divisor
  task automatic test_divide();
    send_instr(OP_DIV, 5'd13, 5'd2, 5'd3);
    send_instr(OP_DIV, 5'd14, 5'd6, 5'd7);
    send_instr(OP_DIV, 5'd15, 5'd6, 5'd5);
    send_instr(OP_DIV, 5'd16, 5'd6, 5'd8);
  endtask

  // Remainder with the divisor added when negative, also for negative divisors
  task automatic test_modulo();
    send_instr(OP_MOD, 5'd17, 5'd6, 5'd7);
    send_instr(OP_MOD, 5'd18, 5'd6, 5'd8);
    send_instr(OP_MOD, 5'd19, 5'd2, 5'd3);
    send_instr(OP_MOD, 5'd20, 5'd1, 5'd5);
    send_instr(OP_MOD, 5'd21, 5'd8, 5'd7);
  endtask

  // Undefined opcodes report the untouched destination
  task automatic test_undefined_ops();
    send_instr(OP_UNDEF_LO, 5'd1, 5'd2, 5'd3, VAL_MIN);
    send_instr(OP_UNDEF_HI, 5'd2, 5'd1, 5'd4, VAL_MAX);
  endtask

  task automatic test_random_program(int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      send_instr(pick_op(), 5'($urandom), 5'($urandom), 5'($urandom), pick_immediate());
      if (n % 250 == 249) wait_drained();
    end
  endtask

  // Back-to-back items with the receiver always ready
  task automatic test_steady_tail(int unsigned count);
    steady_tail = 1'b1;
    test_random_program(count);
  endtask

  initial begin
    for (int i = 0; i < 32; i++) shadow_regs[i] = '0;
    @(posedge clk_i iff rst_ni);
    test_load_extremes();
    test_wrapping_arith();
    test_divide();
    test_modulo();
    test_undefined_ops();
    wait_drained();
    test_random_program(RANDOM_ITEMS);
    test_steady_tail(TAIL_ITEMS);
    wait_drained();
    repeat (48) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
